// ----- hdl/bffrs_pkg.sv -----
// Shared constants for the best-fit free-run search unit.
package bffrs_pkg;

    localparam int VAL_W             = 12;
    localparam int CMD_W             = 2;
    localparam int POS_W             = VAL_W + 1;
    localparam int IN_DATA_W         = 16;
    localparam int OUT_DATA_W        = 16;
    localparam int DEF_SLOTS         = 4096;
    localparam int DEF_WORD_BITS     = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

endpackage

// ----- hdl/best_fit_free_run_search_unit.sv -----
// Best-fit free-run search over a slot occupancy map (top level).
//
//  channel  | dir | fields
//  s_axis   | in  | tuser: cmd[1:0]; tdata: value[11:0]
//  m_axis   | out | tdata: run_start[12:0]
//
// Insert and remove pass a prep state; remove walks down the map words when the
// highest slot is removed. Query walks map words up to the highest occupied one
// and each occupied slot above zero (shared find-first-set, one map read port).
// A finished query stalls while the output register still holds a result.
// After reset a clearing pass writes every map word, with s_axis_tready low.
module best_fit_free_run_search_unit #(
    parameter int SLOTS     = bffrs_pkg::DEF_SLOTS,
    parameter int WORD_BITS = bffrs_pkg::DEF_WORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bffrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // value[11:0]
    input  logic [bffrs_pkg::CMD_W-1:0]         s_axis_tuser,   // cmd[1:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bffrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata    // run_start[12:0]
);

    localparam int VAL_W     = bffrs_pkg::VAL_W;
    localparam int POS_W     = bffrs_pkg::POS_W;
    localparam int LIM       = (SLOTS < (1 << VAL_W)) ? SLOTS : (1 << VAL_W);
    localparam int MEM_WORDS = (LIM + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int SH        = VAL_W + BW;
    localparam int RW        = SH + 1;
    localparam int PROD_W    = VAL_W + RW;
    localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_REM   = 4'd4;
    localparam logic [3:0] S_DOWN  = 4'd5;
    localparam logic [3:0] S_QLOAD = 4'd6;
    localparam logic [3:0] S_QSCAN = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [WORD_BITS-1:0] mem [MEM_WORDS];

    logic [3:0]           state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic [VAL_W-1:0]     pos_reg, pos_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic                 rem_reg, rem_next;
    logic [VAL_W-1:0]     k_reg, k_next;
    logic [POS_W-1:0]     prev_reg, prev_next;
    logic [POS_W-1:0]     best_len_reg, best_len_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     best_start_reg, best_start_next;
    logic [VAL_W-1:0]     highest_reg, highest_next;
    logic [WORD_BITS-1:0] work_reg, work_next;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [POS_W-1:0]     out_data_reg, out_data_next;

    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [VAL_W-1:0]     value;
    logic [PROD_W-1:0]    prod;
    logic [AW-1:0]        quot;
    logic                 in_range;
    logic [POS_W-1:0]     word_base;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] ffs_word;
    logic                 ffs_high;
    logic                 ffs_any;
    logic [BW-1:0]        ffs_idx;
    logic [POS_W-1:0]     hit_pos;
    logic [POS_W-1:0]     gap;
    logic                 last_word;
    logic [WORD_BITS-1:0] qword;
    logic [WORD_BITS-1:0] work_left;

    bffrs_ffs #(
        .WORD_BITS (WORD_BITS)
    ) u_ffs (
        .word (ffs_word),
        .high (ffs_high),
        .any  (ffs_any),
        .idx  (ffs_idx)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = bffrs_pkg::OUT_DATA_W'(out_data_reg);

    assign value     = s_axis_tdata[VAL_W-1:0];
    assign prod      = PROD_W'(value) * PROD_W'(RECIP);
    assign quot      = prod[SH +: AW];
    assign in_range  = ({20'd0, value} < 32'(SLOTS));
    assign word_base = POS_W'(addr_reg) * POS_W'(WORD_BITS);
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign hit_pos   = base_reg + POS_W'(ffs_idx);
    assign gap       = hit_pos - prev_reg - POS_W'(1);
    assign last_word = (base_reg + POS_W'(WORD_BITS)) > {1'b0, highest_reg};
    assign qword     = rdata_reg & ~((addr_reg == '0) ? WORD_BITS'(1) : '0);
    assign work_left = work_reg & ~(WORD_BITS'(1) << ffs_idx);

    always_comb
    begin
        ffs_high = 1'b1;
        ffs_word = rdata_reg;
        unique case (state_reg)
            S_REM:   ffs_word = rdata_reg & ~bit_mask;
            S_QSCAN:
            begin
                ffs_word = work_reg;
                ffs_high = 1'b0;
            end
            default: ffs_word = rdata_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        base_next       = base_reg;
        pos_next        = pos_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        k_next          = k_reg;
        prev_next       = prev_reg;
        best_len_next   = best_len_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        highest_next    = highest_reg;
        work_next       = work_reg;
        out_valid_next  = out_valid_reg & ~m_axis_tready;
        out_data_next   = out_data_reg;
        we              = 1'b0;
        wdata           = rdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                wdata = (addr_reg == '0) ? WORD_BITS'(1) : '0;
                if (addr_reg == AW'(MEM_WORDS - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pos_next = value;
                    if (s_axis_tuser == bffrs_pkg::CMD_INSERT && in_range)
                    begin
                        addr_next  = quot;
                        rem_next   = 1'b0;
                        state_next = S_PREP;
                    end
                    else if (s_axis_tuser == bffrs_pkg::CMD_REMOVE && in_range
                             && value != '0)
                    begin
                        addr_next  = quot;
                        rem_next   = 1'b1;
                        state_next = S_PREP;
                    end
                    else if (s_axis_tuser == bffrs_pkg::CMD_QUERY)
                    begin
                        addr_next       = '0;
                        base_next       = '0;
                        k_next          = (value == '0) ? VAL_W'(1) : value;
                        prev_next       = '0;
                        found_next      = 1'b0;
                        best_len_next   = '0;
                        best_start_next = {1'b0, highest_reg} + POS_W'(1);
                        state_next      = S_QLOAD;
                    end
                end
            end
            S_PREP:
            begin
                base_next  = word_base;
                bit_next   = BW'({1'b0, pos_reg} - word_base);
                state_next = rem_reg ? S_REM : S_INS;
            end
            S_INS:
            begin
                we    = 1'b1;
                wdata = rdata_reg | bit_mask;
                if (pos_reg > highest_reg)
                begin
                    highest_next = pos_reg;
                end
                state_next = S_IDLE;
            end
            S_REM:
            begin
                state_next = S_IDLE;
                if ((rdata_reg & bit_mask) != '0)
                begin
                    we    = 1'b1;
                    wdata = rdata_reg & ~bit_mask;
                    if (pos_reg == highest_reg)
                    begin
                        if (ffs_any)
                        begin
                            highest_next = hit_pos[VAL_W-1:0];
                        end
                        else
                        begin
                            addr_next  = addr_reg - AW'(1);
                            base_next  = base_reg - POS_W'(WORD_BITS);
                            state_next = S_DOWN;
                        end
                    end
                end
            end
            S_DOWN:
            begin
                if (ffs_any)
                begin
                    highest_next = hit_pos[VAL_W-1:0];
                    state_next   = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg - AW'(1);
                    base_next = base_reg - POS_W'(WORD_BITS);
                end
            end
            S_QLOAD:
            begin
                if (qword != '0)
                begin
                    work_next  = qword;
                    state_next = S_QSCAN;
                end
                else if (last_word)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                    base_next = base_reg + POS_W'(WORD_BITS);
                end
            end
            S_QSCAN:
            begin
                if (gap >= {1'b0, k_reg} && (!found_reg || gap < best_len_reg))
                begin
                    best_len_next   = gap;
                    best_start_next = prev_reg + POS_W'(1);
                    found_next      = 1'b1;
                end
                prev_next = hit_pos;
                work_next = work_left;
                if (work_left == '0)
                begin
                    if (last_word)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        addr_next  = addr_reg + AW'(1);
                        base_next  = base_reg + POS_W'(WORD_BITS);
                        state_next = S_QLOAD;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_start_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // map port: write at current word, read the word selected for next cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_reg] <= wdata;
        end
        rdata_reg <= mem[addr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            highest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        pos_reg        <= pos_next;
        bit_reg        <= bit_next;
        rem_reg        <= rem_next;
        k_reg          <= k_next;
        prev_reg       <= prev_next;
        best_len_reg   <= best_len_next;
        found_reg      <= found_next;
        best_start_reg <= best_start_next;
        work_reg       <= work_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// ----- hdl/bffrs_ffs.sv -----
// Find-first-set over one map word, lowest or highest set bit.
module bffrs_ffs #(
    parameter int WORD_BITS = bffrs_pkg::DEF_WORD_BITS
) (
    input  logic [WORD_BITS-1:0]         word,
    input  logic                         high,
    output logic                         any,
    output logic [$clog2(WORD_BITS)-1:0] idx
);

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] rev;
    logic [WORD_BITS-1:0] src;
    logic [WORD_BITS-1:0] iso;
    logic [BW-1:0]        enc;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            rev[i] = word[WORD_BITS-1-i];
        end
        src = high ? rev : word;
        iso = src & (~src + WORD_BITS'(1));
        enc = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (iso[i])
            begin
                enc = enc | BW'(i);
            end
        end
        any = |word;
        idx = high ? (BW'(WORD_BITS - 1) - enc) : enc;
    end

endmodule
